// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define FFA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit frame allocator: codes, widths, shared types.
// No dependencies.
package ffa_pkg;

    localparam int unsigned FRAMES_DEF = 4096;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned OFF_W      = 5;
    localparam int unsigned LIM_W      = 13;
    localparam int unsigned FRM_W      = 12;
    localparam int unsigned WI_W       = LIM_W - OFF_W;
    localparam int unsigned LIM_RST    = 4096;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_RESERVE = 2'd2
    } ffa_mode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_RANGE = 2'd2
    } ffa_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_RESP
    } ffa_state_t;

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] off;
        logic [LIM_W-1:0] run;
    } ffa_scan_t;

endpackage

// ----- rtl/ffa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ffa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/ffa_word_scan.sv -----
// Evaluates one 32-frame map word for the first-fit search.
// Depends on ffa_pkg.
module ffa_word_scan (
    input  logic [ffa_pkg::WORD_W-1:0] used,
    input  logic [ffa_pkg::WORD_W-1:0] lim_mask,
    input  logic [ffa_pkg::LIM_W-1:0]  run_in,
    input  logic [ffa_pkg::LIM_W-1:0]  count,
    output ffa_pkg::ffa_scan_t         res
);
    import ffa_pkg::*;

    localparam int unsigned LVLS = OFF_W + 1;

    logic [WORD_W-1:0] free_bits;
    logic              lv [LVLS][WORD_W];
    logic [OFF_W-1:0]  li [LVLS][WORD_W];
    logic [LIM_W:0]    run_i [WORD_W];
    logic [WORD_W-1:0] hit_i;

    assign free_bits = ~used & lim_mask;

    // prefix scan: index of the last used bit at or below each position
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            lv[0][i] = ~free_bits[i];
            li[0][i] = OFF_W'(i);
        end
        for (int l = 1; l < LVLS; l++) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (!lv[l-1][i] && i >= (1 << (l-1))) begin
                    lv[l][i] = lv[l-1][i - (1 << (l-1))];
                    li[l][i] = li[l-1][i - (1 << (l-1))];
                end else begin
                    lv[l][i] = lv[l-1][i];
                    li[l][i] = li[l-1][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            if (lv[LVLS-1][i]) begin
                run_i[i] = (LIM_W+1)'(OFF_W'(i) - li[LVLS-1][i]);
            end else begin
                run_i[i] = {1'b0, run_in} + (LIM_W+1)'(i + 1);
            end
            hit_i[i] = free_bits[i] && (run_i[i] >= {1'b0, count});
        end
    end

    always_comb begin
        res.hit = 1'b0;
        res.off = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (hit_i[i]) begin
                res.hit = 1'b1;
                res.off = OFF_W'(i);
            end
        end
        if (lv[LVLS-1][WORD_W-1]) begin
            res.run = LIM_W'(OFF_W'(WORD_W - 1) - li[LVLS-1][WORD_W-1]);
        end else begin
            res.run = run_in + LIM_W'(WORD_W);
        end
    end
endmodule

// ----- rtl/first_fit_frame_allocator_top.sv -----
// First-fit frame allocator: top level with map RAM and request sequencer.
// Depends on ffa_pkg, ffa_ram, ffa_word_scan.
//
// Usage:
//  s_ channel takes one request per transaction: s_tuser is the mode
//  (allocate, free, reserve), s_tdata carries start frame and frame count.
//  m_ channel returns one result per request: status in m_tuser, start
//  frame of an allocated run in m_tdata (zero otherwise).
//  cfg_wr_en/cfg_wr_data set the frame limit; write only while idle.
//  The used/free map sits in a RAM of 32 marks per word.
//  Allocate: words are scanned up to the hit or the limit (128 for a full
//  4096-frame scan), then the words of the run are marked when one is found.
//  Free/reserve: each 32-frame word of the range is read and rewritten.
//  One request is worked at a time; s_tready is high only when idle.
//  After reset a clearing pass marks every frame used, one word per cycle;
//  s_tready stays low meanwhile.
//  A stalled m_ side holds the result; the next request is taken but its
//  result waits until the previous one is delivered.
module first_fit_frame_allocator_top #(
    parameter int unsigned FRAMES = ffa_pkg::FRAMES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // start_frame[11:0], frame_count[24:12]
    input  logic [1:0]                 s_tuser,   // mode[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // found_frame[11:0]
    output logic [1:0]                 m_tuser,   // status[1:0]
    input  logic                       cfg_wr_en,
    input  logic [ffa_pkg::LIM_W-1:0]  cfg_wr_data
);
    import ffa_pkg::*;

    localparam int unsigned DEPTH  = ((FRAMES + WORD_W - 1) / WORD_W < 2) ? 2 :
                                     (FRAMES + WORD_W - 1) / WORD_W;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned FR_CAP = (FRAMES > 8191) ? 8191 : FRAMES;

    ffa_state_t        state_reg, state_next;
    logic [LIM_W-1:0]  count_reg, count_next;
    logic [LIM_W-1:0]  lim_reg;
    logic [LIM_W-1:0]  lo_reg, lo_next;
    logic [LIM_W-1:0]  hi_reg, hi_next;
    logic              mark_reg, mark_next;
    logic [WI_W-1:0]   rd_w_reg, rd_w_next;
    logic [WI_W-1:0]   ev_w_reg, ev_w_next;
    logic              pend_reg, pend_next;
    logic [LIM_W-1:0]  run_reg, run_next;
    logic [1:0]        stat_reg, stat_next;
    logic [FRM_W-1:0]  found_reg, found_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic [FRM_W-1:0]  m_found_reg, m_found_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic [LIM_W-1:0]  elim;
    logic [WI_W-1:0]   lim_last_w;
    logic [WI_W-1:0]   hi_last_w;
    logic [LIM_W-1:0]  hi_m1;
    logic [WORD_W-1:0] lim_mask, mask_lo, mask_hi, fill_mask;
    logic [FRM_W-1:0]  in_start;
    logic [LIM_W-1:0]  in_count;
    logic [LIM_W:0]    in_sum;
    logic [LIM_W-1:0]  fpos, hit_pos;
    ffa_scan_t         scan;

    assign in_start = s_tdata[FRM_W-1:0];
    assign in_count = s_tdata[FRM_W +: LIM_W];
    assign in_sum   = {2'b00, in_start} + {1'b0, in_count};

    assign elim       = (lim_reg > LIM_W'(FR_CAP)) ? LIM_W'(FR_CAP) : lim_reg;
    assign lim_last_w = WI_W'((elim - LIM_W'(1)) >> OFF_W);
    assign hi_m1      = hi_reg - LIM_W'(1);
    assign hi_last_w  = hi_m1[LIM_W-1:OFF_W];

    // frames at or above the limit look used to the search
    always_comb begin
        if (ev_w_reg < elim[LIM_W-1:OFF_W]) begin
            lim_mask = '1;
        end else if (ev_w_reg == elim[LIM_W-1:OFF_W]) begin
            lim_mask = ~({WORD_W{1'b1}} << elim[OFF_W-1:0]);
        end else begin
            lim_mask = '0;
        end
    end

    always_comb begin
        if (ev_w_reg > lo_reg[LIM_W-1:OFF_W]) begin
            mask_lo = '1;
        end else if (ev_w_reg == lo_reg[LIM_W-1:OFF_W]) begin
            mask_lo = {WORD_W{1'b1}} << lo_reg[OFF_W-1:0];
        end else begin
            mask_lo = '0;
        end
        if (ev_w_reg < hi_reg[LIM_W-1:OFF_W]) begin
            mask_hi = '1;
        end else if (ev_w_reg == hi_reg[LIM_W-1:OFF_W]) begin
            mask_hi = ~({WORD_W{1'b1}} << hi_reg[OFF_W-1:0]);
        end else begin
            mask_hi = '0;
        end
        fill_mask = mask_lo & mask_hi;
    end

    ffa_word_scan u_scan (
        .used     (ram_rdata),
        .lim_mask (lim_mask),
        .run_in   (run_reg),
        .count    (count_reg),
        .res      (scan)
    );

    assign hit_pos = {ev_w_reg, scan.off};
    assign fpos    = (count_reg == '0) ? hit_pos : hit_pos + LIM_W'(1) - count_reg;

    ffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(rd_w_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lim_reg      <= LIM_W'(LIM_RST);
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                lim_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mark_reg    <= mark_next;
        rd_w_reg    <= rd_w_next;
        ev_w_reg    <= ev_w_next;
        run_reg     <= run_next;
        stat_reg    <= stat_next;
        found_reg   <= found_next;
        m_tuser_reg <= m_tuser_next;
        m_found_reg <= m_found_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mark_next     = mark_reg;
        rd_w_next     = rd_w_reg;
        ev_w_next     = ev_w_reg;
        pend_next     = 1'b0;
        run_next      = run_reg;
        stat_next     = stat_reg;
        found_next    = found_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_found_next  = m_found_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(ev_w_reg);
        ram_wdata     = (ram_rdata & ~fill_mask) | (mark_reg ? fill_mask : '0);
        s_tready      = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    count_next = in_count;
                    found_next = '0;
                    rd_w_next  = '0;
                    run_next   = '0;
                    state_next = S_RESP;
                    stat_next  = STAT_RANGE;
                    case (s_tuser)
                        MODE_ALLOC: begin
                            if (elim == '0) begin
                                stat_next = STAT_OOM;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_FREE, MODE_RESERVE: begin
                            if (in_sum > {1'b0, elim}) begin
                                stat_next = STAT_RANGE;
                            end else if (in_count == '0) begin
                                stat_next = STAT_DONE;
                            end else begin
                                state_next = S_FILL;
                                lo_next    = {1'b0, in_start};
                                hi_next    = in_sum[LIM_W-1:0];
                                mark_next  = (s_tuser == MODE_RESERVE);
                                rd_w_next  = WI_W'(in_start >> OFF_W);
                            end
                        end
                        default: begin
                            stat_next = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                pend_next = 1'b1;
                rd_w_next = rd_w_reg + WI_W'(1);
                ev_w_next = rd_w_reg;
                if (pend_reg) begin
                    if (scan.hit) begin
                        found_next = fpos[FRM_W-1:0];
                        if (count_reg == '0) begin
                            stat_next  = STAT_DONE;
                            state_next = S_RESP;
                        end else begin
                            lo_next    = fpos;
                            hi_next    = fpos + count_reg;
                            mark_next  = 1'b1;
                            rd_w_next  = fpos[LIM_W-1:OFF_W];
                            pend_next  = 1'b0;
                            state_next = S_FILL;
                        end
                    end else if (ev_w_reg == lim_last_w) begin
                        stat_next  = STAT_OOM;
                        found_next = '0;
                        state_next = S_RESP;
                    end else begin
                        run_next = scan.run;
                    end
                end
            end
            S_FILL: begin
                // read of the next word overlaps the write of this one
                pend_next = 1'b1;
                rd_w_next = rd_w_reg + WI_W'(1);
                ev_w_next = rd_w_reg;
                if (pend_reg) begin
                    ram_we = 1'b1;
                    if (ev_w_reg == hi_last_w) begin
                        stat_next  = STAT_DONE;
                        pend_next  = 1'b0;
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stat_reg;
                    m_found_next  = found_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {4'h0, m_found_reg};
endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checker for the frame allocator, bound to the top level.
// Depends on ffa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ffa_pkg::*;

    `FFA_ASSERT_NEXT_ALWAYS(a_rst_no_result, aclk, !aresetn, !m_tvalid, "result after reset")

    `FFA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken while busy")

    `FFA_ASSERT_NOW(a_fail_no_frame, aclk, aresetn, m_tvalid && m_tuser != STAT_DONE, m_tdata == 16'h0, "failed request returns a frame")

    `FFA_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped under stall")
endmodule

bind first_fit_frame_allocator_top ffa_checker u_ffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_first_fit_frame_allocator_top.sv -----
// Self-checking testbench for first_fit_frame_allocator_top.
// Depends on ffa_pkg and the allocator RTL; it predicts every result from its
// own copy of the frame map and checks the m_ channel in order.
module tb_first_fit_frame_allocator_top;
    import ffa_pkg::*;

    localparam int NFRM = 4096;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] start;
        logic [12:0] count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] found;
    } rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [LIM_W-1:0] cfg_wr_data = '0;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    bit          map_used[NFRM];
    int unsigned frame_lim;
    int          mismatches = 0;
    int          rsp_seen = 0;
    int          req_sent = 0;
    int          ooms = 0;
    int          ranges = 0;
    int unsigned cycles = 0;
    bit          hold_req = 0;
    bit          hold_used = 0;

    first_fit_frame_allocator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic void mark_range(int unsigned first, int unsigned n, bit val);
        for (int unsigned k = 0; k < n; k++)
            if (first + k < NFRM) map_used[first + k] = val;
    endfunction

    function automatic rsp_t allocate_or_mark(req_t r);
        rsp_t        res;
        int unsigned lim;
        int unsigned run;
        bit          hit;
        lim = (frame_lim > NFRM) ? NFRM : frame_lim;
        res.status = STAT_RANGE;
        res.found = '0;
        run = 0;
        hit = 0;
        if (r.mode == MODE_ALLOC) begin
            for (int unsigned i = 0; i < lim && !hit; i++) begin
                if (map_used[i]) begin
                    run = 0;
                end else if (r.count == 0) begin
                    res.found = i[11:0];
                    hit = 1;
                end else begin
                    run++;
                    if (run == r.count) begin
                        res.found = 12'(i + 1 - r.count);
                        hit = 1;
                    end
                end
            end
            if (hit) begin
                mark_range(res.found, r.count, 1'b1);
                res.status = STAT_DONE;
            end else begin
                res.status = STAT_OOM;
                res.found = '0;
            end
        end else if (r.mode == MODE_FREE || r.mode == MODE_RESERVE) begin
            if (r.start + r.count <= lim) begin
                mark_range(r.start, r.count, r.mode == MODE_RESERVE);
                res.status = STAT_DONE;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("MISMATCH rsp %0d %s: got %0d expected %0d", rsp_seen, what, got, want);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        logic  nv;
        req_t  r;
        nv = s_tvalid;
        if (s_tvalid && s_tready) begin
            r.mode = s_tuser;
            r.start = s_tdata[11:0];
            r.count = s_tdata[24:12];
            expected_rsps.push_back(allocate_or_mark(r));
            req_sent++;
            nv = 1'b0;
        end
        if (!nv && aresetn) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_tdata <= {7'b0, r.count, r.start};
                s_tuser <= r.mode;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
        s_tvalid <= nv;
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    int hold_left = 0;
    int stall_style = 0;
    always @(posedge aclk) begin
        logic [1:0] st;
        cycles++;
        if (m_tvalid && m_tready) begin
            st = m_tuser;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected transaction", st, -1);
            end else begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (st != e.status) report_mismatch("status", st, e.status);
                if (m_tdata != {4'b0, e.found}) report_mismatch("found_frame", m_tdata, e.found);
                if (e.status == STAT_OOM) ooms++;
                if (e.status == STAT_RANGE) ranges++;
            end
            rsp_seen++;
        end
        if (hold_req && !hold_used) begin
            hold_used = 1;
            hold_left = 3000;
        end
        if (cycles % 250 == 0) stall_style = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_style == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, stall_style) == 0);
        end
    end

    always @(posedge aclk) begin
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic req_t mk(logic [1:0] m, int unsigned s, int unsigned n);
        req_t r;
        r.mode = m;
        r.start = s[11:0];
        r.count = n[12:0];
        return r;
    endfunction

    // Mostly small runs; now and then a whole-map or oversized count.
    function automatic req_t rand_req();
        int unsigned sel;
        int unsigned n;
        sel = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 48);
        if (sel < 45) return mk(MODE_ALLOC, $urandom_range(0, 4095), n);
        if (sel < 80) return mk(MODE_FREE, $urandom_range(0, 4095) >> $urandom_range(0, 6), n);
        if (sel < 97) return mk(MODE_RESERVE, $urandom_range(0, 4095), n);
        return mk(2'd3, $urandom_range(0, 4095), n);
    endfunction

    task automatic drain_and_set_limit(int unsigned lim);
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_rsps.size() == 0);
        repeat (300) @(posedge aclk);
        wait (s_tready);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lim[LIM_W-1:0];
        frame_lim = lim & 13'h1fff;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    int unsigned limits[6] = '{8191, 0, 1, 37, 4096, 2000};

    initial begin
        for (int i = 0; i < NFRM; i++) map_used[i] = 1'b1;
        frame_lim = LIM_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (s_tready);

        // Directed: map starts all used, so open it up and probe the edges.
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 0));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 1));
        pending_reqs.push_back(mk(MODE_FREE, 0, 4096));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 4096));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 0));
        pending_reqs.push_back(mk(MODE_FREE, 4095, 1));
        pending_reqs.push_back(mk(MODE_ALLOC, 4095, 1));
        pending_reqs.push_back(mk(MODE_FREE, 4095, 2));
        pending_reqs.push_back(mk(MODE_FREE, 4095, 0));
        pending_reqs.push_back(mk(MODE_FREE, 0, 8191));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 8191));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 4097));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 4096));
        pending_reqs.push_back(mk(MODE_RESERVE, 100, 10));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 95));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 5));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 6));
        pending_reqs.push_back(mk(MODE_RESERVE, 0, 4096));
        pending_reqs.push_back(mk(MODE_ALLOC, 0, 0));
        pending_reqs.push_back(mk(2'd3, 4095, 8191));
        pending_reqs.push_back(mk(2'd3, 0, 0));
        pending_reqs.push_back(mk(MODE_FREE, 2048, 2048));
        pending_reqs.push_back(mk(MODE_ALLOC, 1234, 2048));
        for (int i = 0; i < 80; i++) pending_reqs.push_back(rand_req());

        foreach (limits[p]) begin
            drain_and_set_limit(limits[p]);
            if (limits[p] == 4096) hold_req = 1;
            // Reopen part of the map so allocations keep succeeding.
            pending_reqs.push_back(mk(MODE_FREE, 0, limits[p] > 4096 ? 4096 : limits[p]));
            for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
        end

        wait (pending_reqs.size() == 0 && !s_tvalid && expected_rsps.size() == 0);
        repeat (300) @(posedge aclk);
        $display("covered %0d requests, %0d responses (%0d out of memory, %0d bad range)",
                 req_sent, rsp_seen, ooms, ranges);
        $display("frame limits 4096, 8191, 0, 1, 37, 4096, 2000 with one long output stall");
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_word_scan.sv
rtl/first_fit_frame_allocator_top.sv
rtl/ffa_checker.sv
tb/sv/tb_first_fit_frame_allocator_top.sv
